FILE: rtl/core/swm_pkg.sv
`default_nettype none

package swm_pkg;

  // width of the window_size configuration register
  localparam int CFG_BITS = 7;

  // per-cycle command broadcast to every cell of the queue
  typedef struct packed {
    logic step;     // a new sample enters this cycle
    logic shift;    // every cell takes its right neighbor (head is dropped)
    logic restart;  // discard the stored candidates before the sample enters
  } swm_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/swm_cell.sv
`default_nettype none

module swm_cell import swm_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int AGE_BITS    = 7,
  parameter int WINDOW_MAX  = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire swm_ctrl_t                     ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          left_kept,
  input  wire logic                          right_valid,
  input  wire logic signed [SAMPLE_BITS-1:0] right_value,
  input  wire logic        [AGE_BITS-1:0]    right_age,
  output logic                               valid,
  output logic signed      [SAMPLE_BITS-1:0] value,
  output logic             [AGE_BITS-1:0]    age,
  output logic                               kept,
  output logic signed      [SAMPLE_BITS-1:0] value_next
);

  localparam logic [AGE_BITS-1:0] AGE_CAP = AGE_BITS'(WINDOW_MAX);

  logic                          src_valid;
  logic signed [SAMPLE_BITS-1:0] src_value;
  logic        [AGE_BITS-1:0]    src_age;
  logic                          place;
  logic                          valid_next;
  logic        [AGE_BITS-1:0]    age_next;

  always_comb begin
    src_valid = ctrl.shift ? right_valid : valid;
    src_value = ctrl.shift ? right_value : value;
    src_age   = ctrl.shift ? right_age   : age;

    // candidates not smaller than the new sample survive; they form a prefix
    kept  = src_valid && !ctrl.restart && (src_value >= sample);
    // the new sample lands just past the last survivor
    place = !kept && left_kept;

    if (ctrl.step) begin
      valid_next = kept || place;
      value_next = kept ? src_value : sample;
      if (!kept) begin
        age_next = '0;
      end else if (src_age >= AGE_CAP) begin
        age_next = AGE_CAP;
      end else begin
        age_next = src_age + 1'b1;
      end
    end else begin
      valid_next = src_valid;
      value_next = src_value;
      age_next   = src_age;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    value <= value_next;
    age   <= age_next;
  end

endmodule

`default_nettype wire

FILE: rtl/core/sliding_window_maximum_top.sv
// Sliding window maximum filter.
// Input channel: sample and restart, taken when in_valid and in_ready are
// both high. Set restart on the first word of a new sequence. Output channel:
// window_max, delivered when out_valid and out_ready are both high. Once
// window_size words of the current sequence have arrived (0 counts as 1,
// capped at WINDOW_MAX), every input word gives one output word; earlier
// words give none. out_valid rises in the cycle after input acceptance, and
// the filter takes one word per cycle while in_ready is high: all cells of
// the candidate queue update from their neighbors together.
// When the receiver stalls, the output register holds its word and in_ready
// drops until it is taken. Writing window_size (cfg_we) takes effect for the
// next word; while the block is idle it then drops candidates that have left
// the shortened window, one per cycle, with in_ready low. Reset empties the
// queue, clears the sample count, drops out_valid and sets window_size to 1.
`default_nettype none

module sliding_window_maximum_top import swm_pkg::*; #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic        [CFG_BITS-1:0]    window_size,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          restart,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed      [SAMPLE_BITS-1:0] window_max
);

  localparam int AGE_BITS = $clog2(WINDOW_MAX + 1);
  localparam int EW       = (AGE_BITS > CFG_BITS) ? AGE_BITS : CFG_BITS;
  localparam logic [EW-1:0]       W_CAP    = EW'(WINDOW_MAX);
  localparam logic [AGE_BITS-1:0] SEEN_CAP = AGE_BITS'(WINDOW_MAX);

  logic [CFG_BITS-1:0] cfg_window;
  logic                trim;
  logic [AGE_BITS-1:0] seen;

  logic [EW-1:0]       w_ext;
  logic [EW-1:0]       w_eff;
  logic [EW-1:0]       head_age;
  logic                accept;
  logic                trim_drop;
  logic                step_drop;
  logic [AGE_BITS-1:0] seen_base;
  logic [AGE_BITS-1:0] seen_next;
  logic                out_hit;
  swm_ctrl_t           ctrl;

  logic                          cell_valid [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];
  logic        [AGE_BITS-1:0]    cell_age   [WINDOW_MAX];
  logic                          cell_kept  [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] cell_next  [WINDOW_MAX];

  always_comb begin
    w_ext = EW'(cfg_window);
    if (w_ext == '0) begin
      w_eff = EW'(1);
    end else if (w_ext > W_CAP) begin
      w_eff = W_CAP;
    end else begin
      w_eff = w_ext;
    end

    head_age = EW'(cell_age[0]);
    in_ready = !trim && (!out_valid || out_ready);
    accept   = in_valid && in_ready;

    // ages are distinct and below the window, so at most one head leaves per word
    step_drop = cell_valid[0] && (head_age >= w_eff - EW'(1));
    trim_drop = trim && cell_valid[0] && (head_age >= w_eff);

    ctrl.step    = accept;
    ctrl.shift   = accept ? step_drop : trim_drop;
    ctrl.restart = restart;

    seen_base = restart ? '0 : seen;
    seen_next = (seen_base < SEEN_CAP) ? seen_base + 1'b1 : seen_base;
    out_hit   = EW'(seen_next) >= w_eff;
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic                          left_kept;
    logic                          right_valid;
    logic signed [SAMPLE_BITS-1:0] right_value;
    logic        [AGE_BITS-1:0]    right_age;

    if (i == 0) begin : g_head
      assign left_kept = 1'b1;
    end else begin : g_body
      assign left_kept = cell_kept[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_value = '0;
      assign right_age   = '0;
    end else begin : g_link
      assign right_valid = cell_valid[i+1];
      assign right_value = cell_value[i+1];
      assign right_age   = cell_age[i+1];
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_BITS    (AGE_BITS),
      .WINDOW_MAX  (WINDOW_MAX)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .sample      (sample),
      .left_kept   (left_kept),
      .right_valid (right_valid),
      .right_value (right_value),
      .right_age   (right_age),
      .valid       (cell_valid[i]),
      .value       (cell_value[i]),
      .age         (cell_age[i]),
      .kept        (cell_kept[i]),
      .value_next  (cell_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_window <= CFG_BITS'(1);
      trim       <= 1'b0;
      seen       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_window <= window_size;
        trim       <= 1'b1;
      end else if (trim && !trim_drop) begin
        trim <= 1'b0;
      end
      if (accept) begin
        seen      <= seen_next;
        out_valid <= out_hit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    // the head after the update is the window maximum
    if (accept) begin
      window_max <= cell_next[0];
    end
  end

endmodule

`default_nettype wire
